@@ design/lld_pkg.sv @@
// ----------------------------------------------------------------------------
// Line distance package
// Shared widths, result flag bundle and saturation helpers for the closest
// distance pipeline.
// ----------------------------------------------------------------------------
package lld_pkg;

  localparam int WORD_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WIDE_W        = 64;
  localparam int EXT_W         = 66;
  localparam int QUOT_W        = 33;
  localparam int ROOT_W        = 32;
  localparam int IN_FIELDS     = 12;

  localparam logic signed [EXT_W-1:0] SAT_HI = (EXT_W'(1) <<< (WORD_W - 1)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] SAT_LO = -(EXT_W'(1) <<< (WORD_W - 1));

  typedef logic signed [WORD_W-1:0] word_t;

  // Packed so that lines_parallel lands in bit 0 of tuser.
  typedef struct packed {
    logic saturated;
    logic zero_divisor;
    logic lines_parallel;
  } lld_flags_t;

  function automatic logic sat_hit(input logic signed [EXT_W-1:0] x);
    return (x > SAT_HI) || (x < SAT_LO);
  endfunction

  function automatic word_t sat_val(input logic signed [EXT_W-1:0] x);
    word_t r;
    if (x > SAT_HI) begin
      r = WORD_W'(SAT_HI);
    end else if (x < SAT_LO) begin
      r = WORD_W'(SAT_LO);
    end else begin
      r = WORD_W'(x);
    end
    return r;
  endfunction

endpackage

@@ design/lld_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, preceded by a stage that flags quotients that
// do not fit in QUOT_W bits. Side data travels along with each word.
// ----------------------------------------------------------------------------
module lld_div #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [lld_pkg::WIDE_W-1:0] in_num,
  input  logic [lld_pkg::WIDE_W-1:0] in_den,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  output logic [lld_pkg::QUOT_W-1:0] out_quot,
  output logic                      out_ovf,
  output logic [SIDE_W-1:0]         out_side
);
  import lld_pkg::*;

  localparam int DIV_W = WIDE_W + QUOT_W;

  logic              v0;
  logic [WIDE_W-1:0] r0, d0;
  logic              ovf0;
  logic [SIDE_W-1:0] side0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0    <= in_num;
      d0    <= in_den;
      ovf0  <= DIV_W'(in_num) >= (DIV_W'(in_den) << QUOT_W);
      side0 <= in_side;
    end
  end

  logic              v_q    [0:QUOT_W-1];
  logic [WIDE_W-1:0] r_q    [0:QUOT_W-1];
  logic [WIDE_W-1:0] d_q    [0:QUOT_W-1];
  logic [QUOT_W-1:0] q_q    [0:QUOT_W-1];
  logic              ovf_q  [0:QUOT_W-1];
  logic [SIDE_W-1:0] side_q [0:QUOT_W-1];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    localparam int J = QUOT_W - 1 - k;
    logic              v_i, ovf_i, ge;
    logic [WIDE_W-1:0] r_i, d_i;
    logic [QUOT_W-1:0] q_i, q_n;
    logic [SIDE_W-1:0] side_i;
    logic [DIV_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign v_i    = v0;
      assign r_i    = r0;
      assign d_i    = d0;
      assign q_i    = '0;
      assign ovf_i  = ovf0;
      assign side_i = side0;
    end else begin : g_next
      assign v_i    = v_q[k-1];
      assign r_i    = r_q[k-1];
      assign d_i    = d_q[k-1];
      assign q_i    = q_q[k-1];
      assign ovf_i  = ovf_q[k-1];
      assign side_i = side_q[k-1];
    end

    assign trial = DIV_W'(d_i) << J;
    assign ge    = DIV_W'(r_i) >= trial;

    always_comb begin
      q_n    = q_i;
      q_n[J] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        // The remainder stays below the shifted divisor, so 64 bits hold it.
        r_q[k]    <= ge ? (r_i - WIDE_W'(trial)) : r_i;
        d_q[k]    <= d_i;
        q_q[k]    <= q_n;
        ovf_q[k]  <= ovf_i;
        side_q[k] <= side_i;
      end
    end
  end

  assign out_valid = v_q[QUOT_W-1];
  assign out_quot  = q_q[QUOT_W-1];
  assign out_ovf   = ovf_q[QUOT_W-1];
  assign out_side  = side_q[QUOT_W-1];

endmodule

@@ design/lld_isqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Bitwise digit-by-digit root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module lld_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [lld_pkg::WIDE_W-1:0] in_n,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  output logic [lld_pkg::ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0]         out_side
);
  import lld_pkg::*;

  logic              v_q    [0:ROOT_W-1];
  logic [WIDE_W-1:0] n_q    [0:ROOT_W-1];
  logic [WIDE_W-1:0] r_q    [0:ROOT_W-1];
  logic [SIDE_W-1:0] side_q [0:ROOT_W-1];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int SH = WIDE_W - 2 - 2 * i;
    localparam logic [WIDE_W-1:0] BITV = WIDE_W'(1) << SH;
    logic              v_i, ge;
    logic [WIDE_W-1:0] n_i, r_i, t;
    logic [SIDE_W-1:0] side_i;

    if (i == 0) begin : g_first
      assign v_i    = in_valid;
      assign n_i    = in_n;
      assign r_i    = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_q[i-1];
      assign n_i    = n_q[i-1];
      assign r_i    = r_q[i-1];
      assign side_i = side_q[i-1];
    end

    assign t  = r_i + BITV;
    assign ge = n_i >= t;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[i]    <= ge ? (n_i - t) : n_i;
        r_q[i]    <= ge ? ((r_i >> 1) + BITV) : (r_i >> 1);
        side_q[i] <= side_i;
      end
    end
  end

  assign out_valid = v_q[ROOT_W-1];
  assign out_root  = r_q[ROOT_W-1][ROOT_W-1:0];
  assign out_side  = side_q[ROOT_W-1];

endmodule

@@ design/line_to_line_closest_distance_core.sv @@
// ----------------------------------------------------------------------------
// Closest distance between two 3D lines
// Fixed-point pipeline: dot products, determinant, two dividers, residual
// vector and a pipelined square root.
// ----------------------------------------------------------------------------
// Usage:
// A line pair enters on the s_ stream as one 384-bit word: point a, point b,
// direction a, direction b, each x, y, z in signed Q16.16, lowest bits first.
// The result leaves on the m_ stream: the distance in unsigned Q16.16 on
// m_tdata and the flags lines_parallel, zero_divisor, saturated on m_tuser.
// The cfg channel writes the parallel threshold; it is always ready and
// should only be written while no word is in flight.
// Throughput is one line pair per cycle while s_tready is high. The accepting
// edge loads the first of 78 registers on the way to m_tvalid: six
// arithmetic stages, the 34-stage divider (overflow check plus one quotient
// bit per stage), five more arithmetic stages, the 32-stage square root and
// the output register.
// When the receiver stalls, one more word drops into a skid register and then
// the whole pipeline freezes with s_tready low; nothing is lost or repeated.
// Reset clears all valid bits and sets the threshold to 1 (2^-16).
// ----------------------------------------------------------------------------
module line_to_line_closest_distance_core #(
  parameter int FRAC_BITS = lld_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z,
  // dir_a_x, dir_a_y, dir_a_z, dir_b_x, dir_b_y, dir_b_z (32 bits each)
  input  logic [383:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // distance
  output logic [31:0] m_tdata,
  // lines_parallel, zero_divisor, saturated
  output logic [2:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import lld_pkg::*;

  localparam int VEC3_W = 3 * WORD_W;
  localparam int SC_SIDE_W = $bits(lld_flags_t) + 1 + 3 * VEC3_W;

  logic [WORD_W-1:0] threshold;
  logic              en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= WORD_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  assign s_tready = en;

  // ---------------- S1: offset w = point_a - point_b ----------------
  word_t pa [3], pb [3], ui [3], vi [3];
  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign pa[k] = s_tdata[WORD_W*k +: WORD_W];
    assign pb[k] = s_tdata[WORD_W*(3+k) +: WORD_W];
    assign ui[k] = s_tdata[WORD_W*(6+k) +: WORD_W];
    assign vi[k] = s_tdata[WORD_W*(9+k) +: WORD_W];
  end

  logic  s1_v, s1_sat;
  word_t s1_w [3], s1_u [3], s1_v3 [3];
  logic signed [EXT_W-1:0] diff [3];
  for (genvar k = 0; k < 3; k++) begin : g_diff
    assign diff[k] = EXT_W'(pa[k]) - EXT_W'(pb[k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_w[k]  <= sat_val(diff[k]);
        s1_u[k]  <= ui[k];
        s1_v3[k] <= vi[k];
      end
      s1_sat <= sat_hit(diff[0]) || sat_hit(diff[1]) || sat_hit(diff[2]);
    end
  end

  // ---------------- S2: fifteen products, floored ----------------
  // Rows: 0 = u.u, 1 = u.v, 2 = v.v, 3 = u.w, 4 = v.w
  logic signed [WIDE_W-1:0] pr [5][3];
  for (genvar k = 0; k < 3; k++) begin : g_p2
    assign pr[0][k] = s1_u[k] * s1_u[k];
    assign pr[1][k] = s1_u[k] * s1_v3[k];
    assign pr[2][k] = s1_v3[k] * s1_v3[k];
    assign pr[3][k] = s1_u[k] * s1_w[k];
    assign pr[4][k] = s1_v3[k] * s1_w[k];
  end

  logic s2_v, s2_sat;
  logic signed [WIDE_W-1:0] s2_fp [5][3];
  word_t s2_w [3], s2_u [3], s2_v3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 5; r++) begin
        for (int k = 0; k < 3; k++) begin
          s2_fp[r][k] <= pr[r][k] >>> FRAC_BITS;
        end
      end
      s2_w   <= s1_w;
      s2_u   <= s1_u;
      s2_v3  <= s1_v3;
      s2_sat <= s1_sat;
    end
  end

  // ---------------- S3: sums a..e ----------------
  logic signed [EXT_W-1:0] dsum [5];
  for (genvar r = 0; r < 5; r++) begin : g_sum
    assign dsum[r] = EXT_W'(s2_fp[r][0]) + EXT_W'(s2_fp[r][1]) + EXT_W'(s2_fp[r][2]);
  end

  logic  s3_v, s3_sat;
  word_t s3_dot [5];
  word_t s3_w [3], s3_u [3], s3_v3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 5; r++) begin
        s3_dot[r] <= sat_val(dsum[r]);
      end
      s3_sat <= s2_sat || sat_hit(dsum[0]) || sat_hit(dsum[1]) || sat_hit(dsum[2]) ||
                sat_hit(dsum[3]) || sat_hit(dsum[4]);
      s3_w  <= s2_w;
      s3_u  <= s2_u;
      s3_v3 <= s2_v3;
    end
  end

  // ---------------- S4: products of the dot products ----------------
  logic s4_v, s4_sat;
  logic signed [WIDE_W-1:0] s4_ac, s4_bb, s4_be, s4_cd, s4_ae, s4_bd;
  word_t s4_b, s4_c, s4_d, s4_e;
  word_t s4_w [3], s4_u [3], s4_v3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ac  <= s3_dot[0] * s3_dot[2];
      s4_bb  <= s3_dot[1] * s3_dot[1];
      s4_be  <= s3_dot[1] * s3_dot[4];
      s4_cd  <= s3_dot[2] * s3_dot[3];
      s4_ae  <= s3_dot[0] * s3_dot[4];
      s4_bd  <= s3_dot[1] * s3_dot[3];
      s4_b   <= s3_dot[1];
      s4_c   <= s3_dot[2];
      s4_d   <= s3_dot[3];
      s4_e   <= s3_dot[4];
      s4_sat <= s3_sat;
      s4_w   <= s3_w;
      s4_u   <= s3_u;
      s4_v3  <= s3_v3;
    end
  end

  // ---------------- S5: determinant and numerators ----------------
  logic signed [WIDE_W-1:0] det_full;
  assign det_full = s4_ac - s4_bb;

  logic s5_v, s5_sat;
  logic signed [WIDE_W-1:0] s5_det, s5_nsc, s5_ntc;
  word_t s5_b, s5_c, s5_d, s5_e;
  word_t s5_w [3], s5_u [3], s5_v3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_det <= det_full >>> FRAC_BITS;
      s5_nsc <= s4_be - s4_cd;
      s5_ntc <= s4_ae - s4_bd;
      s5_b   <= s4_b;
      s5_c   <= s4_c;
      s5_d   <= s4_d;
      s5_e   <= s4_e;
      s5_sat <= s4_sat;
      s5_w   <= s4_w;
      s5_u   <= s4_u;
      s5_v3  <= s4_v3;
    end
  end

  // ---------------- S6: case split and divider operands ----------------
  logic                     par, b_gt_c, zdiv;
  logic signed [WIDE_W-1:0] num_tc, num_par;
  logic [WIDE_W-1:0]        den_tc, mag_sc, mag_tc;

  always_comb begin
    par     = $signed({s5_det[WIDE_W-1], s5_det}) < $signed({1'b0, WIDE_W'(threshold)});
    b_gt_c  = s5_b > s5_c;
    num_par = WIDE_W'(b_gt_c ? s5_d : s5_e) <<< FRAC_BITS;
    // In the parallel case the chosen divisor is never negative.
    if (par) begin
      num_tc = num_par;
      den_tc = WIDE_W'(unsigned'(b_gt_c ? s5_b : s5_c));
      zdiv   = !b_gt_c && (s5_c == '0);
    end else begin
      num_tc = s5_ntc;
      den_tc = s5_det;
      zdiv   = (s5_det == '0);
    end
    mag_sc = s5_nsc[WIDE_W-1] ? WIDE_W'(-s5_nsc) : WIDE_W'(s5_nsc);
    mag_tc = num_tc[WIDE_W-1] ? WIDE_W'(-num_tc) : WIDE_W'(num_tc);
  end

  logic              s6_v;
  lld_flags_t        s6_flags;
  logic              s6_neg_sc, s6_neg_tc;
  logic [WIDE_W-1:0] s6_num_sc, s6_num_tc, s6_den_sc, s6_den_tc;
  logic [VEC3_W-1:0] s6_w, s6_u, s6_v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_flags.lines_parallel <= par;
      s6_flags.zero_divisor   <= zdiv;
      s6_flags.saturated      <= s5_sat;
      s6_neg_sc <= s5_nsc[WIDE_W-1];
      s6_neg_tc <= num_tc[WIDE_W-1];
      s6_num_sc <= mag_sc;
      s6_num_tc <= mag_tc;
      s6_den_sc <= s5_det;
      s6_den_tc <= den_tc;
      s6_w      <= {s5_w[2], s5_w[1], s5_w[0]};
      s6_u      <= {s5_u[2], s5_u[1], s5_u[0]};
      s6_v3     <= {s5_v3[2], s5_v3[1], s5_v3[0]};
    end
  end

  // ---------------- Dividers ----------------
  logic                 dv_sc, dv_tc, ovf_sc, ovf_tc;
  logic [QUOT_W-1:0]    q_sc, q_tc;
  logic [SC_SIDE_W-1:0] side_sc;
  logic                 side_tc;

  lld_div #(.SIDE_W(SC_SIDE_W)) u_div_sc (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s6_v),
    .in_num   (s6_num_sc),
    .in_den   (s6_den_sc),
    .in_side  ({s6_flags, s6_neg_sc, s6_w, s6_u, s6_v3}),
    .out_valid(dv_sc),
    .out_quot (q_sc),
    .out_ovf  (ovf_sc),
    .out_side (side_sc)
  );

  lld_div #(.SIDE_W(1)) u_div_tc (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s6_v),
    .in_num   (s6_num_tc),
    .in_den   (s6_den_tc),
    .in_side  (s6_neg_tc),
    .out_valid(dv_tc),
    .out_quot (q_tc),
    .out_ovf  (ovf_tc),
    .out_side (side_tc)
  );

  lld_flags_t        d_flags;
  logic              d_neg_sc;
  logic [VEC3_W-1:0] d_w, d_u, d_v3;
  assign {d_flags, d_neg_sc, d_w, d_u, d_v3} = side_sc;

  // ---------------- S7: quotient saturation ----------------
  function automatic logic [WORD_W:0] quot_sat(input logic [QUOT_W-1:0] q,
                                               input logic ovf, input logic neg);
    logic [QUOT_W-1:0] lim;
    logic              hit;
    word_t             val;
    lim = QUOT_W'(1) << (WORD_W - 1);
    if (neg) begin
      hit = ovf || (q > lim);
      val = hit ? WORD_W'(SAT_LO) : WORD_W'(-q);
    end else begin
      hit = ovf || (q > lim - QUOT_W'(1));
      val = hit ? WORD_W'(SAT_HI) : WORD_W'(q);
    end
    return {hit, val};
  endfunction

  logic [WORD_W:0] qs_sc, qs_tc;
  logic            sc_zero, tc_zero;
  assign qs_sc   = quot_sat(q_sc, ovf_sc, d_neg_sc);
  assign qs_tc   = quot_sat(q_tc, ovf_tc, side_tc);
  assign sc_zero = d_flags.lines_parallel || d_flags.zero_divisor;
  assign tc_zero = d_flags.zero_divisor;

  logic       s7_v;
  lld_flags_t s7_flags;
  word_t      s7_sc, s7_tc;
  word_t      s7_w [3], s7_u [3], s7_v3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= dv_sc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_sc <= sc_zero ? '0 : qs_sc[WORD_W-1:0];
      s7_tc <= tc_zero ? '0 : qs_tc[WORD_W-1:0];
      s7_flags.lines_parallel <= d_flags.lines_parallel;
      s7_flags.zero_divisor   <= d_flags.zero_divisor;
      s7_flags.saturated      <= d_flags.saturated || (!sc_zero && qs_sc[WORD_W]) ||
                                 (!tc_zero && qs_tc[WORD_W]);
      for (int k = 0; k < 3; k++) begin
        s7_w[k]  <= d_w[WORD_W*k +: WORD_W];
        s7_u[k]  <= d_u[WORD_W*k +: WORD_W];
        s7_v3[k] <= d_v3[WORD_W*k +: WORD_W];
      end
    end
  end

  // ---------------- S8: sc*u and tc*v, floored ----------------
  logic signed [WIDE_W-1:0] p_su [3], p_tv [3];
  for (genvar k = 0; k < 3; k++) begin : g_p8
    assign p_su[k] = s7_sc * s7_u[k];
    assign p_tv[k] = s7_tc * s7_v3[k];
  end

  logic       s8_v;
  lld_flags_t s8_flags;
  logic signed [WIDE_W-1:0] s8_su [3], s8_tv [3];
  word_t      s8_w [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (en) begin
      s8_v <= s7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s8_su[k] <= p_su[k] >>> FRAC_BITS;
        s8_tv[k] <= p_tv[k] >>> FRAC_BITS;
      end
      s8_w     <= s7_w;
      s8_flags <= s7_flags;
    end
  end

  // ---------------- S9: residual components, magnitudes ----------------
  logic signed [EXT_W-1:0] comp [3];
  word_t                   comp_s [3];
  logic [WORD_W-1:0]       comp_m [3];
  for (genvar k = 0; k < 3; k++) begin : g_comp
    assign comp[k]   = EXT_W'(s8_w[k]) + EXT_W'(s8_su[k]) - EXT_W'(s8_tv[k]);
    assign comp_s[k] = sat_val(comp[k]);
    // The most negative value maps to 2^31, which still fits unsigned.
    assign comp_m[k] = comp_s[k][WORD_W-1] ? (~comp_s[k] + WORD_W'(1)) : comp_s[k];
  end

  logic              s9_v;
  lld_flags_t        s9_flags;
  logic [WORD_W-1:0] s9_mag [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (en) begin
      s9_v <= s8_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_mag <= comp_m;
      s9_flags.lines_parallel <= s8_flags.lines_parallel;
      s9_flags.zero_divisor   <= s8_flags.zero_divisor;
      s9_flags.saturated      <= s8_flags.saturated || sat_hit(comp[0]) ||
                                 sat_hit(comp[1]) || sat_hit(comp[2]);
    end
  end

  // ---------------- S10: squares ----------------
  logic              s10_v;
  lld_flags_t        s10_flags;
  logic [WIDE_W-1:0] s10_sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_v <= 1'b0;
    end else if (en) begin
      s10_v <= s9_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s10_sq[k] <= WIDE_W'(s9_mag[k]) * WIDE_W'(s9_mag[k]);
      end
      s10_flags <= s9_flags;
    end
  end

  // ---------------- S11: sum of squares ----------------
  // Each square is at most 2^62, so the sum fits in 64 bits.
  logic              s11_v;
  lld_flags_t        s11_flags;
  logic [WIDE_W-1:0] s11_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_v <= 1'b0;
    end else if (en) begin
      s11_v <= s10_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_sum   <= s10_sq[0] + s10_sq[1] + s10_sq[2];
      s11_flags <= s10_flags;
    end
  end

  // ---------------- Square root ----------------
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  lld_flags_t        sq_flags;

  lld_isqrt #(.SIDE_W($bits(lld_flags_t))) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s11_v),
    .in_n     (s11_sum),
    .in_side  (s11_flags),
    .out_valid(sq_v),
    .out_root (sq_root),
    .out_side (sq_flags)
  );

  // ---------------- Output register and skid word ----------------
  logic              out_v, skid_v;
  logic [ROOT_W-1:0] out_d, skid_d;
  lld_flags_t        out_f, skid_f;
  logic              push;

  assign en   = !skid_v;
  assign push = en && sq_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && !m_tready) begin
      if (push) begin
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      out_v  <= 1'b1;
      skid_v <= 1'b0;
    end else begin
      out_v <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v && !m_tready) begin
      if (push) begin
        skid_d <= sq_root;
        skid_f <= sq_flags;
      end
    end else if (skid_v) begin
      out_d <= skid_d;
      out_f <= skid_f;
    end else begin
      out_d <= sq_root;
      out_f <= sq_flags;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_d;
  assign m_tuser  = out_f;

`ifndef SYNTH
  // Both dividers see the same valid stream and must stay in lockstep.
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    dv_sc == dv_tc)
    else $error("divider lanes out of step");

  // The skid word is only ever filled behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid word held with empty output register");

  // A frozen pipeline must not change the root at its end.
  a_freeze_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(sq_root) && $stable(sq_v))
    else $error("pipeline moved while stalled");

  // A word can only leave the skid register when the output slot frees up.
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_v && out_v && !m_tready |=> skid_v)
    else $error("skid word dropped during stall");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Closest line distance core testbench
// Drives line pairs through the stream port under random idling, predicts
// distance and flags in fixed point and checks every result word in order.
// ----------------------------------------------------------------------------
module tb;
  import lld_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = 78;
  localparam int N_RANDOM = 1100;

  typedef struct packed {
    logic [31:0] distance;
    logic        saturated;
    logic        zero_divisor;
    logic        lines_parallel;
  } line_result_t;

  typedef struct {
    logic [383:0] pair;
    logic         typed;
    line_result_t res;
  } stim_row_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [383:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [31:0]  m_tdata;
  logic [2:0]   m_tuser;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;

  line_result_t expected_q[$];
  logic [31:0]  threshold;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           errors;
  stim_row_t    rows[$];

  always #5 clk = ~clk;

  line_to_line_closest_distance_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic longint floor_q(longint x);
    return x >>> FB;
  endfunction

  function automatic longint clip32(longint x, ref bit sat);
    if (x > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic logic [31:0] root64(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r[31:0];
  endfunction

  function automatic line_result_t predict_distance(logic [383:0] pair, logic [31:0] thr);
    longint pa[3], pb[3], u[3], v[3], w[3];
    longint a, b, c, d, e, det, sc, tc, comp;
    logic [63:0] mag, sum;
    bit sat, par, zdiv;
    line_result_t r;
    sat = 0; par = 0; zdiv = 0; sc = 0; tc = 0; sum = 0;
    for (int i = 0; i < 3; i++) begin
      pa[i] = longint'($signed(pair[32*i +: 32]));
      pb[i] = longint'($signed(pair[32*(3+i) +: 32]));
      u[i]  = longint'($signed(pair[32*(6+i) +: 32]));
      v[i]  = longint'($signed(pair[32*(9+i) +: 32]));
      w[i]  = clip32(pa[i] - pb[i], sat);
    end
    a = clip32(floor_q(u[0]*u[0]) + floor_q(u[1]*u[1]) + floor_q(u[2]*u[2]), sat);
    b = clip32(floor_q(u[0]*v[0]) + floor_q(u[1]*v[1]) + floor_q(u[2]*v[2]), sat);
    c = clip32(floor_q(v[0]*v[0]) + floor_q(v[1]*v[1]) + floor_q(v[2]*v[2]), sat);
    d = clip32(floor_q(u[0]*w[0]) + floor_q(u[1]*w[1]) + floor_q(u[2]*w[2]), sat);
    e = clip32(floor_q(v[0]*w[0]) + floor_q(v[1]*w[1]) + floor_q(v[2]*w[2]), sat);
    det = floor_q(a*c - b*b);
    if (det < longint'({32'd0, thr})) begin
      par = 1;
      if (b > c) tc = clip32((d <<< FB) / b, sat);
      else if (c != 0) tc = clip32((e <<< FB) / c, sat);
      else zdiv = 1;
    end else if (det == 0) begin
      zdiv = 1;
    end else begin
      sc = clip32((b*e - c*d) / det, sat);
      tc = clip32((a*e - b*d) / det, sat);
    end
    for (int i = 0; i < 3; i++) begin
      comp = clip32(w[i] + floor_q(sc*u[i]) - floor_q(tc*v[i]), sat);
      mag = comp < 0 ? -comp : comp;
      sum = sum + mag*mag;
    end
    r.distance = root64(sum);
    r.lines_parallel = par;
    r.zero_divisor = zdiv;
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [383:0] make_pair(logic [31:0] f[12]);
    logic [383:0] p;
    for (int i = 0; i < 12; i++) p[32*i +: 32] = f[i];
    return p;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      3: return 32'($signed($urandom_range(0, 65535)) - 32768) <<< $urandom_range(0, 8);
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  // Random line pair; some have parallel or zero directions to reach those branches.
  function automatic logic [383:0] rand_pair();
    logic [31:0] f[12];
    int k;
    for (int i = 0; i < 12; i++) f[i] = rand_word();
    case ($urandom_range(0, 7))
      0: for (int i = 0; i < 3; i++) f[9+i] = f[6+i];
      1: begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < 3; i++) f[9+i] = f[6+i] * k;
      end
      2: for (int i = 0; i < 3; i++) f[9+i] = '0;
      3: for (int i = 0; i < 6; i++) f[6+i] = '0;
      default: ;
    endcase
    return make_pair(f);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("result word with no expectation: distance %h flags %b", m_tdata, m_tuser);
          errors++;
        end else begin
          line_result_t x;
          x = expected_q.pop_front();
          if (m_tdata !== x.distance) begin
            $error("distance expected %h actual %h", x.distance, m_tdata);
            errors++;
          end
          if (m_tuser[0] !== x.lines_parallel) begin
            $error("lines_parallel expected %b actual %b", x.lines_parallel, m_tuser[0]);
            errors++;
          end
          if (m_tuser[1] !== x.zero_divisor) begin
            $error("zero_divisor expected %b actual %b", x.zero_divisor, m_tuser[1]);
            errors++;
          end
          if (m_tuser[2] !== x.saturated) begin
            $error("saturated expected %b actual %b", x.saturated, m_tuser[2]);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // The word stays valid after acceptance; the caller drops tvalid when it
  // idles, so back-to-back words keep tvalid high without a gap.
  task automatic send_pair(logic [383:0] pair);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= pair;
    expected_q.push_back(predict_distance(pair, threshold));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] value);
    cfg_valid <= 1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    threshold = value;
    @(posedge clk);
  endtask

  task automatic add_row(logic [31:0] f[12], logic typed, line_result_t r);
    stim_row_t s;
    s.pair = make_pair(f);
    s.typed = typed;
    s.res = r;
    rows.push_back(s);
  endtask

  task automatic build_rows();
    logic [31:0] f[12];
    line_result_t none;
    none = '0;
    // All zero: parallel with zero denominator, distance zero.
    f = '{default: 32'h0};
    add_row(f, 1, '{distance: 0, saturated: 0, zero_divisor: 1, lines_parallel: 1});
    // Zero directions, point offset of 3 on x only.
    f = '{default: 32'h0};
    f[0] = 32'h0003_0000;
    add_row(f, 1, '{distance: 32'h0003_0000, saturated: 0, zero_divisor: 1,
                    lines_parallel: 1});
    // Extreme offset saturates the difference.
    f = '{default: 32'h0};
    f[0] = 32'h7fffffff;
    f[3] = 32'h80000000;
    add_row(f, 0, none);
    f = '{default: 32'h80000000};
    add_row(f, 0, none);
    f = '{default: 32'h7fffffff};
    add_row(f, 0, none);
    // Unit axes, skew lines one apart on z.
    f = '{default: 32'h0};
    f[2] = 32'h0001_0000;
    f[6] = 32'h0001_0000;
    f[10] = 32'h0001_0000;
    add_row(f, 0, none);
    // Parallel along x, offset on y; b > c branch with longer dir_a.
    f = '{default: 32'h0};
    f[1] = 32'h0002_0000;
    f[6] = 32'h0003_0000;
    f[9] = 32'h0001_0000;
    add_row(f, 0, none);
    // Parallel, dir_a shorter so tc comes from e / c.
    f = '{default: 32'h0};
    f[4] = 32'hfffe_0000;
    f[6] = 32'h0001_0000;
    f[9] = 32'h0002_0000;
    add_row(f, 0, none);
    // Tiny directions whose determinant rounds negative.
    f = '{default: 32'h0};
    f[0] = 32'h0000_1000;
    f[6] = 32'h0000_0003;
    f[7] = 32'h0000_0001;
    f[9] = 32'h0000_0001;
    f[10] = 32'hffff_ffff;
    add_row(f, 0, none);
    for (int k = 0; k < 12; k++) begin
      for (int i = 0; i < 12; i++) f[i] = rand_word();
      add_row(f, 0, none);
    end
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      send_pair(rand_pair());
      // Halfway through, the sender holds off until the pipeline has emptied.
      if (i == count / 2) begin
        s_tvalid <= 0;
        while (expected_q.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    errors = 0;
    threshold = 32'd1;
    send_idle_pct = 26;
    recv_idle_pct = 47;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    build_rows();
    foreach (rows[i]) begin
      send_pair(rows[i].pair);
      if (rows[i].typed) begin
        if (expected_q[$] !== rows[i].res) begin
          $error("table row %0d predicted %h typed %h", i, expected_q[$], rows[i].res);
          errors++;
        end
        expected_q[$] = rows[i].res;
      end
    end
    drain();

    // Threshold zero lets a zero determinant through to the divider.
    write_threshold(32'd0);
    for (int i = 0; i < 4; i++) begin
      logic [31:0] f[12];
      f = '{default: 32'h0};
      f[i % 3] = 32'h0005_0000;
      f[6 + (i % 3)] = 32'h0001_0000;
      f[9 + (i % 3)] = 32'h0001_0000;
      send_pair(make_pair(f));
    end
    random_phase(200);
    drain();

    send_idle_pct = 47;
    recv_idle_pct = 26;
    write_threshold(32'hffffffff);
    random_phase(200);
    drain();

    write_threshold($urandom);
    random_phase(200);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_threshold(32'h0001_0000);
    random_phase(250);
    drain();

    write_threshold(32'd1);
    random_phase(250);
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
